// File: hw/rtl/punctuation_tokenizer_defines.svh
// assertion macros for the punctuation tokenizer checker
// expects i_clk and i_rst_n in the scope of use
`ifndef PUNCTUATION_TOKENIZER_DEFINES_SVH
`define PUNCTUATION_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("punctuation tokenizer check failed");

// next-cycle implication, disabled in reset
`define PT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("punctuation tokenizer check failed");

`endif

// File: hw/rtl/punct_pkg.sv
// punctuation tokenizer package: token kinds, character codes, result type
// and the lookup functions used by the step logic; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package punct_pkg;

    typedef enum logic [4:0] {
        K_LPAREN   = 5'd0,
        K_RPAREN   = 5'd1,
        K_LBRACE   = 5'd2,
        K_RBRACE   = 5'd3,
        K_COLON    = 5'd4,
        K_SEMI     = 5'd5,
        K_COMMA    = 5'd6,
        K_PLUS     = 5'd7,
        K_STAR     = 5'd8,
        K_SLASH    = 5'd9,
        K_PERCENT  = 5'd10,
        K_ARROW    = 5'd11,
        K_MINUS    = 5'd12,
        K_EQ       = 5'd13,
        K_FATARROW = 5'd14,
        K_ASSIGN   = 5'd15,
        K_NOTEQ    = 5'd16,
        K_BANG     = 5'd17,
        K_LTEQ     = 5'd18,
        K_LT       = 5'd19,
        K_GTEQ     = 5'd20,
        K_GT       = 5'd21,
        K_AND      = 5'd22,
        K_OR       = 5'd23,
        K_OTHER    = 5'd24,
        K_ERROR    = 5'd25
    } t_kind;

    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  passed;
        logic        last;
    } t_tok;

    typedef struct packed {
        logic v0;
        logic v1;
        t_tok t0;
        t_tok t1;
    } t_step_res;

    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_LPAREN:  k = K_LPAREN;
            CH_RPAREN:  k = K_RPAREN;
            CH_LBRACE:  k = K_LBRACE;
            CH_RBRACE:  k = K_RBRACE;
            CH_COLON:   k = K_COLON;
            CH_SEMI:    k = K_SEMI;
            CH_COMMA:   k = K_COMMA;
            CH_PLUS:    k = K_PLUS;
            CH_STAR:    k = K_STAR;
            CH_PERCENT: k = K_PERCENT;
            default:    k = K_OTHER;
        endcase
        return k;
    endfunction

    // one-byte form of a held byte; & and | alone are errors
    function automatic t_kind single_form(input logic [7:0] p);
        t_kind k;
        case (p)
            CH_MINUS: k = K_MINUS;
            CH_EQ:    k = K_ASSIGN;
            CH_BANG:  k = K_BANG;
            CH_LT:    k = K_LT;
            CH_GT:    k = K_GT;
            CH_SLASH: k = K_SLASH;
            default:  k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic may_pend(input logic [7:0] c);
        return (c == CH_MINUS) || (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) ||
               (c == CH_GT) || (c == CH_SLASH) || (c == CH_AMP) || (c == CH_BAR);
    endfunction

    function automatic logic pair_hit(input logic [7:0] p, input logic [7:0] c);
        return (p == CH_MINUS && c == CH_GT) || (p == CH_EQ && c == CH_EQ) ||
               (p == CH_EQ && c == CH_GT) || (p == CH_BANG && c == CH_EQ) ||
               (p == CH_LT && c == CH_EQ) || (p == CH_GT && c == CH_EQ) ||
               (p == CH_AMP && c == CH_AMP) || (p == CH_BAR && c == CH_BAR);
    endfunction

    function automatic t_kind pair_kind(input logic [7:0] p, input logic [7:0] c);
        t_kind k;
        case (p)
            CH_MINUS: k = K_ARROW;
            CH_EQ:    k = (c == CH_GT) ? K_FATARROW : K_EQ;
            CH_BANG:  k = K_NOTEQ;
            CH_LT:    k = K_LTEQ;
            CH_GT:    k = K_GTEQ;
            CH_AMP:   k = K_AND;
            CH_BAR:   k = K_OR;
            default:  k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/punct_if.sv
// valid/ready channel interfaces for source bytes and tokens
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface punct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_source;

    modport source (output valid, output char_byte, output end_of_source, input ready);
    modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

interface punct_tok_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [7:0]  passed_byte;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_line,
                    output token_column, output passed_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input token_line,
                  input token_column, input passed_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/punct_step.sv
// lexer state and the single-pass step logic for one source byte
// depends on punct_pkg
`timescale 1ns / 1ps
`default_nettype none

module punct_step #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [7:0]           i_char,
    input  wire logic                 i_eos,
    output punct_pkg::t_step_res      o_res
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    logic [7:0]               r_pend_char, n_pend_char;
    logic                     r_pend_valid, n_pend_valid;
    logic [POSITION_BITS-1:0] r_pend_line, n_pend_line;
    logic [POSITION_BITS-1:0] r_pend_col, n_pend_col;
    logic                     r_in_comment, n_in_comment;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic                     r_halted, n_halted;

    punct_pkg::t_tok  w_a, w_b, w_c;
    logic             w_a_v, w_b_v, w_c_v;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] cap16(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (|w[31:16]) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic punct_pkg::t_tok mk_tok(input punct_pkg::t_kind k,
                                               input logic [POSITION_BITS-1:0] ln,
                                               input logic [POSITION_BITS-1:0] cl,
                                               input logic [7:0] b);
        punct_pkg::t_tok t;
        t.kind   = k;
        t.line   = cap16(ln);
        t.column = cap16(cl);
        t.passed = (k >= punct_pkg::K_OTHER) ? b : 8'h00;
        t.last   = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic            stop;
        logic            consumed;
        punct_pkg::t_kind k;
        n_pend_char  = r_pend_char;
        n_pend_valid = r_pend_valid;
        n_pend_line  = r_pend_line;
        n_pend_col   = r_pend_col;
        n_in_comment = r_in_comment;
        n_line       = r_line;
        n_col        = r_col;
        n_halted     = r_halted;
        w_a = '0; w_b = '0; w_c = '0;
        w_a_v = 1'b0; w_b_v = 1'b0; w_c_v = 1'b0;
        stop = 1'b0;
        consumed = 1'b0;
        k = punct_pkg::K_OTHER;
        if (!r_halted) begin
            // resolve the held byte against this one
            if (r_pend_valid) begin
                n_pend_valid = 1'b0;
                if (r_pend_char == punct_pkg::CH_SLASH && i_char == punct_pkg::CH_SLASH) begin
                    n_in_comment = 1'b1;
                    n_col = sat_inc(r_col);
                    consumed = 1'b1;
                end else if (punct_pkg::pair_hit(r_pend_char, i_char)) begin
                    w_a = mk_tok(punct_pkg::pair_kind(r_pend_char, i_char),
                                 r_pend_line, r_pend_col, 8'h00);
                    w_a_v = 1'b1;
                    n_col = sat_inc(r_col);
                    consumed = 1'b1;
                end else begin
                    k = punct_pkg::single_form(r_pend_char);
                    w_a = mk_tok(k, r_pend_line, r_pend_col, r_pend_char);
                    w_a_v = 1'b1;
                    if (k == punct_pkg::K_ERROR) begin
                        n_halted = 1'b1;
                        stop = 1'b1;
                    end
                end
            end
            // fresh byte
            if (!stop && !consumed) begin
                if (i_char == punct_pkg::CH_NL) begin
                    n_in_comment = 1'b0;
                    n_line = sat_inc(r_line);
                    n_col = POS_ONE;
                end else if (r_in_comment || i_char == punct_pkg::CH_SP ||
                             i_char == punct_pkg::CH_TAB || i_char == punct_pkg::CH_CR) begin
                    n_col = sat_inc(r_col);
                end else if (punct_pkg::may_pend(i_char)) begin
                    n_pend_char  = i_char;
                    n_pend_valid = 1'b1;
                    n_pend_line  = r_line;
                    n_pend_col   = r_col;
                    n_col = sat_inc(r_col);
                end else begin
                    w_b = mk_tok(punct_pkg::single_kind(i_char), r_line, r_col, i_char);
                    w_b_v = 1'b1;
                    n_col = sat_inc(r_col);
                end
            end
            // end of source: flush and rewind
            if (!stop && i_eos) begin
                if (n_pend_valid) begin
                    k = punct_pkg::single_form(n_pend_char);
                    w_c = mk_tok(k, n_pend_line, n_pend_col, n_pend_char);
                    w_c_v = 1'b1;
                    n_pend_valid = 1'b0;
                    if (k == punct_pkg::K_ERROR) begin
                        n_halted = 1'b1;
                    end
                end
                if (!n_halted) begin
                    n_line = POS_ONE;
                    n_col = POS_ONE;
                    n_in_comment = 1'b0;
                end
            end
        end
    end

    // order results: held-byte token first, then fresh or flushed token
    always_comb begin
        o_res.v0 = i_fire & (w_a_v | w_b_v | w_c_v);
        o_res.v1 = i_fire & w_a_v & (w_b_v | w_c_v);
        o_res.t0 = w_a_v ? w_a : (w_b_v ? w_b : w_c);
        o_res.t0.last = ~(w_a_v & (w_b_v | w_c_v));
        o_res.t1 = w_b_v ? w_b : w_c;
        o_res.t1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_char  <= 8'h00;
            r_pend_valid <= 1'b0;
            r_pend_line  <= POS_ONE;
            r_pend_col   <= POS_ONE;
            r_in_comment <= 1'b0;
            r_line       <= POS_ONE;
            r_col        <= POS_ONE;
            r_halted     <= 1'b0;
        end else if (i_fire) begin
            r_pend_char  <= n_pend_char;
            r_pend_valid <= n_pend_valid;
            r_pend_line  <= n_pend_line;
            r_pend_col   <= n_pend_col;
            r_in_comment <= n_in_comment;
            r_line       <= n_line;
            r_col        <= n_col;
            r_halted     <= n_halted;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/punct_fifo.sv
// small result queue: up to two writes per cycle, one read per cycle
// depends on punct_pkg
`timescale 1ns / 1ps
`default_nettype none

module punct_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire punct_pkg::t_step_res i_res,
    output logic                      o_space_ok,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output punct_pkg::t_tok           o_head
);

    localparam int PW = punct_pkg::RES_PTR_W;
    localparam int CW = punct_pkg::RES_CNT_W;

    punct_pkg::t_tok r_mem [punct_pkg::RES_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            w_pop;

    assign o_valid    = (r_count != '0);
    assign o_head     = r_mem[r_rd];
    assign w_pop      = o_valid & i_ready;
    assign o_space_ok = (r_count <= CW'(punct_pkg::RES_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + PW'(i_res.v0) + PW'(i_res.v1);
        n_rd    = r_rd + PW'(w_pop);
        n_count = r_count + CW'(i_res.v0) + CW'(i_res.v1) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_res.v0) begin
            r_mem[r_wr] <= i_res.t0;
        end
        if (i_res.v1) begin
            r_mem[r_wr + PW'(1)] <= i_res.t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/punctuation_tokenizer.sv
// an accepted source beat is registered, then stepped into the result queue
// throughput: one source byte per cycle while the 4-entry result queue has
// room for two tokens; a byte that yields two tokens writes both into it
// reset: synchronous active-low i_rst_n clears position counters to 1,
// drops the held byte, comment and halt flags, and empties the queue
`timescale 1ns / 1ps
`default_nettype none

module punctuation_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    punct_in_if.sink       i_in,
    punct_tok_if.source    o_tok
);

    logic                 r_in_valid;
    logic [7:0]           r_in_char;
    logic                 r_in_eos;
    logic                 w_fire;
    logic                 w_space_ok;
    logic                 w_accept;
    punct_pkg::t_step_res w_res;
    punct_pkg::t_tok      w_head;

    assign w_fire     = r_in_valid & w_space_ok;
    assign i_in.ready = ~r_in_valid | w_fire;
    assign w_accept   = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_in.char_byte;
            r_in_eos  <= i_in.end_of_source;
        end
    end

    punct_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_char  (r_in_char),
        .i_eos   (r_in_eos),
        .o_res   (w_res)
    );

    punct_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (w_res),
        .o_space_ok (w_space_ok),
        .o_valid    (o_tok.valid),
        .i_ready    (o_tok.ready),
        .o_head     (w_head)
    );

    assign o_tok.token_kind   = w_head.kind;
    assign o_tok.token_line   = w_head.line;
    assign o_tok.token_column = w_head.column;
    assign o_tok.passed_byte  = w_head.passed;
    assign o_tok.last_of_run  = w_head.last;

endmodule

`default_nettype wire

// File: hw/rtl/punct_checker.sv
// port-level checks on the token stream of punctuation_tokenizer
// depends on punct_pkg and punctuation_tokenizer_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "punctuation_tokenizer_defines.svh"

module punct_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_tok_valid,
    input wire logic        i_tok_ready,
    input wire logic [4:0]  i_tok_kind,
    input wire logic [15:0] i_tok_line,
    input wire logic [15:0] i_tok_column,
    input wire logic [7:0]  i_tok_passed
);

    // token beat held until taken
    `PT_ASSERT_NEXT(a_tok_hold, i_tok_valid && !i_tok_ready, i_tok_valid)
    // positions start at one
    `PT_ASSERT_NOW(a_pos_nonzero, i_tok_valid, i_tok_line != 16'h0000 && i_tok_column != 16'h0000)
    // punctuation carries no byte
    `PT_ASSERT_NOW(a_punct_zero, i_tok_valid && i_tok_kind < punct_pkg::K_OTHER, i_tok_passed == 8'h00)
    // error halts: nothing follows it
    `PT_ASSERT_NEXT(a_err_halt, i_tok_valid && i_tok_ready && i_tok_kind == punct_pkg::K_ERROR, !i_tok_valid)

endmodule

bind punctuation_tokenizer punct_checker u_punct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_tok_valid  (o_tok.valid),
    .i_tok_ready  (o_tok.ready),
    .i_tok_kind   (o_tok.token_kind),
    .i_tok_line   (o_tok.token_line),
    .i_tok_column (o_tok.token_column),
    .i_tok_passed (o_tok.passed_byte)
);

`default_nettype wire
